// File: hdl/amdfs_pkg.sv
package amdfs_pkg;

  // Graph size and derived widths
  localparam int unsigned MAX_V = 32;
  localparam int unsigned VW    = $clog2(MAX_V);
  localparam int unsigned CW    = VW + 1;

  // One bit per vertex
  typedef logic [MAX_V-1:0] vmask_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OUTER,
    ST_STEP
  } state_e;

  // Command codes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_RUN   = 1'b1
  } op_e;

  // Result of the shared lowest-bit encoder
  typedef struct packed {
    logic          found;
    logic [VW-1:0] index;
  } lowbit_t;

endpackage

// File: hdl/amdfs_lowbit.sv
module amdfs_lowbit (
  input  amdfs_pkg::vmask_t  bits_i,
  output amdfs_pkg::lowbit_t res_o
);
  import amdfs_pkg::*;

  // Priority encoder: lowest set bit wins
  always_comb begin
    res_o.found = |bits_i;
    res_o.index = '0;
    for (int i = MAX_V - 1; i >= 0; i--) begin
      if (bits_i[i]) begin
        res_o.index = VW'(i);
      end
    end
  end

endmodule

// File: hdl/amdfs_adj.sv
module amdfs_adj (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [amdfs_pkg::VW-1:0] waddr_i,
  input  amdfs_pkg::vmask_t     wdata_i,
  input  logic [amdfs_pkg::VW-1:0] raddr_i,
  output amdfs_pkg::vmask_t     rdata_o
);
  import amdfs_pkg::*;

  vmask_t rows_q [MAX_V];

  // Row storage, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_V; i++) begin
        rows_q[i] <= '0;
      end
    end else if (we_i) begin
      rows_q[waddr_i] <= wdata_i;
    end
  end

  // Row of the vertex on top of the stack
  assign rdata_o = rows_q[raddr_i];

endmodule

// File: hdl/adjacency_matrix_dfs_order_core.sv
// Depth-first visit order over a 32-vertex adjacency bit matrix.
//
// Commands: a transaction is taken when start_i is high and busy_o is low.
// opcode_i = OP_WRITE stores row_bits_i as the adjacency row of row_index_i;
// it finishes in that cycle and busy_o stays low. opcode_i = OP_RUN clears
// the visited marks and walks depth-first over all components, lowest start
// vertex first, lowest unvisited neighbour first, self edges skipped.
// Results: one per visited vertex, shown for one cycle with valid_o high;
// last_o marks the final vertex. The receiver cannot stall the block.
// Configuration: cfg_we_i writes vertex_count (values above 32 saturate);
// write only while busy_o is low. A count of zero gives a run with no output.
// Sequencing: one priority encoder is shared by the start-vertex search and the
// neighbour search. Pushes (each with its result) and pops are separate
// sequencer steps; a component's start vertex is pushed by the start search
// itself, and one final empty start search ends the run. The first result
// strobe is registered from the start search in ST_OUTER, which the
// accepting edge enters.
// Reset: the adjacency matrix clears, vertex_count returns to 32, the
// sequencer goes idle and no result is pending.
module adjacency_matrix_dfs_order_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [0:0]               opcode_i,
  input  logic [4:0]               row_index_i,
  input  logic [31:0]              row_bits_i,
  input  logic                     cfg_we_i,
  input  logic [5:0]               cfg_wdata_i,
  output logic                     valid_o,
  output logic [4:0]               vertex_o,
  output logic                     last_o
);
  import amdfs_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] cfg_q;
  vmask_t        visited_q, visited_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] stack_q [MAX_V];
  logic          valid_q, valid_d;
  logic [VW-1:0] vertex_q, vertex_d;
  logic          last_q, last_d;

  logic          push_en;
  logic [VW-1:0] push_addr;
  logic          accept;
  logic          run_acc;
  logic          wr_acc;
  logic [CW-1:0] n_eff;
  vmask_t        in_use;
  logic [CW-1:0] sp_m1;
  logic [VW-1:0] top_v;
  vmask_t        adj_row;
  vmask_t        cand;
  vmask_t        free;
  vmask_t        enc_in;
  lowbit_t       enc;

  // Command decode
  assign accept  = start_i && (state_q == ST_IDLE);
  assign run_acc = accept && (opcode_i == OP_RUN);
  assign wr_acc  = accept && (opcode_i == OP_WRITE);

  // Vertices in use
  assign n_eff = (cfg_q > CW'(MAX_V)) ? CW'(MAX_V) : cfg_q;
  always_comb begin
    for (int i = 0; i < MAX_V; i++) begin
      in_use[i] = (CW'(i) < n_eff);
    end
  end

  // Top of stack and its row
  assign sp_m1 = sp_q - CW'(1);
  assign top_v = stack_q[sp_m1[VW-1:0]];

  amdfs_adj u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_acc),
    .waddr_i (row_index_i),
    .wdata_i (row_bits_i),
    .raddr_i (top_v),
    .rdata_o (adj_row)
  );

  // Shared encoder input: unvisited starts or unvisited neighbours
  assign free   = in_use & ~visited_q;
  assign cand   = adj_row & free & ~(vmask_t'(1) << top_v);
  assign enc_in = (state_q == ST_OUTER) ? free : cand;

  amdfs_lowbit u_lowbit (
    .bits_i (enc_in),
    .res_o  (enc)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (run_acc) state_d = ST_OUTER;
      end
      ST_OUTER: begin
        state_d = enc.found ? ST_STEP : ST_IDLE;
      end
      ST_STEP: begin
        if (!enc.found && (sp_q == CW'(1))) state_d = ST_OUTER;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result updates
  always_comb begin
    visited_d = visited_q;
    sp_d      = sp_q;
    cnt_d     = cnt_q;
    valid_d   = 1'b0;
    vertex_d  = vertex_q;
    last_d    = last_q;
    push_en   = 1'b0;
    push_addr = sp_q[VW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (run_acc) begin
          visited_d = '0;
          sp_d      = '0;
          cnt_d     = '0;
        end
      end
      ST_OUTER, ST_STEP: begin
        if (enc.found) begin
          visited_d[enc.index] = 1'b1;
          valid_d  = 1'b1;
          vertex_d = enc.index;
          last_d   = ((cnt_q + CW'(1)) == n_eff);
          cnt_d    = cnt_q + CW'(1);
          if (state_q == ST_OUTER) begin
            push_en   = 1'b1;
            push_addr = '0;
            sp_d      = CW'(1);
          end else if (sp_q < CW'(MAX_V)) begin
            push_en = 1'b1;
            sp_d    = sp_q + CW'(1);
          end
        end else if (state_q == ST_STEP) begin
          sp_d = sp_m1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CW'(MAX_V);
      visited_q <= '0;
      sp_q      <= '0;
      cnt_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      sp_q      <= sp_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    vertex_q <= vertex_d;
    last_q   <= last_d;
  end

  // Walk stack
  always_ff @(posedge clk_i) begin
    if (push_en) stack_q[push_addr] <= enc.index;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign vertex_o = vertex_q;
  assign last_o   = valid_q && last_q;

  // A result is never shown once the run has ended
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe while idle");

  // Every emitted vertex is marked visited
  a_emit_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> visited_q[vertex_o])
    else $error("emitted vertex not marked");

  // Stack never grows past MAX_V entries
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(MAX_V))
    else $error("stack pointer overflow");

  // An accepted run makes the block busy
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_acc |=> busy_o)
    else $error("run accepted but not busy");

endmodule
